[rtl/tphf_pkg.sv]
// ----------------------------------------------------------------------------
// tphf_pkg
// Shared types and constants for the tunnel packet header filter.
// ----------------------------------------------------------------------------
package tphf_pkg;

	localparam logic [7:0] MAGIC_A    = 8'h42;
	localparam logic [7:0] MAGIC_B    = 8'h01;
	localparam logic [7:0] SKIP_BYTES = 8'd10;
	// longest address field accepted, source or destination
	localparam logic [7:0] ADDR_MAX   = 8'd31;
	// identity bytes that can match (at most 16)
	localparam logic [4:0] ID_BYTES   = 5'd16;
	localparam logic [4:0] IDX_SAT    = 5'd31;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ID_LOW  = 2'd0,
		REG_ID_HIGH = 2'd1,
		REG_ID_LEN  = 2'd2,
		REG_PORT    = 2'd3
	} cfg_reg_t;

	typedef enum logic [11:0] {
		PH_MAGIC_A     = 12'b0000_0000_0001,
		PH_MAGIC_B     = 12'b0000_0000_0010,
		PH_SRC_LEN     = 12'b0000_0000_0100,
		PH_SRC_ADDR    = 12'b0000_0000_1000,
		PH_SRC_PORT_LO = 12'b0000_0001_0000,
		PH_SRC_PORT_HI = 12'b0000_0010_0000,
		PH_DST_LEN     = 12'b0000_0100_0000,
		PH_DST_ADDR    = 12'b0000_1000_0000,
		PH_DST_PORT_LO = 12'b0001_0000_0000,
		PH_DST_PORT_HI = 12'b0010_0000_0000,
		PH_SKIP        = 12'b0100_0000_0000,
		PH_PAYLOAD     = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [63:0] id_low;
		logic [63:0] id_high;
		logic [4:0]  id_len;
		logic [15:0] port;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic [15:0] src_port;
		logic        first_byte;
		logic        last_byte;
		logic        no_payload;
	} result_t;

endpackage

[rtl/tphf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tphf_cfg_regs
// Identity and port registers, written through the plain write port.
// ----------------------------------------------------------------------------
module tphf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tphf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tphf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tphf_pkg::cfg_t                    cfg
);
	import tphf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.id_low  <= '0;
			cfg_q.id_high <= '0;
			cfg_q.id_len  <= 5'd1;
			cfg_q.port    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ID_LOW:  cfg_q.id_low  <= cfg_data;
				REG_ID_HIGH: cfg_q.id_high <= cfg_data;
				REG_ID_LEN:  cfg_q.id_len  <= cfg_data[4:0];
				REG_PORT:    cfg_q.port    <= cfg_data[15:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/tphf_parser.sv]
// ----------------------------------------------------------------------------
// tphf_parser
// Header parse state machine: one byte per step, at most one result per step.
// ----------------------------------------------------------------------------
module tphf_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        msg_byte,
	input  logic              msg_last,
	input  tphf_pkg::cfg_t    cfg,
	output tphf_pkg::result_t res
);
	import tphf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  field_q, field_d;
	logic [4:0]  idx_q, idx_d;
	logic        match_q, match_d;
	logic [15:0] sport_q, sport_d;
	logic [15:0] dport_q, dport_d;
	logic        drop_q, drop_d;
	logic        started_q, started_d;

	logic [127:0] id_all;
	logic [7:0]   id_sel;
	logic [7:0]   field_dec;
	logic         port_ok;
	result_t      res_d;

	assign id_all    = {cfg.id_high, cfg.id_low};
	assign id_sel    = id_all[{idx_q[3:0], 3'b000} +: 8];
	assign field_dec = field_q - 8'd1;
	assign port_ok   = match_q && (dport_q == cfg.port);

	always_comb begin
		phase_d   = phase_q;
		field_d   = field_q;
		idx_d     = idx_q;
		match_d   = match_q;
		sport_d   = sport_q;
		dport_d   = dport_q;
		drop_d    = drop_q;
		started_d = started_q;

		res_d              = '0;
		res_d.src_port     = sport_q;
		res_d.payload_byte = msg_byte;

		if (!drop_q) begin
			unique case (phase_q)
				PH_MAGIC_A: begin
					if (msg_byte == MAGIC_A) phase_d = PH_MAGIC_B;
					else drop_d = 1'b1;
				end
				PH_MAGIC_B: begin
					if (msg_byte == MAGIC_B) phase_d = PH_SRC_LEN;
					else drop_d = 1'b1;
				end
				PH_SRC_LEN: begin
					if (msg_byte > ADDR_MAX) begin
						drop_d = 1'b1;
					end else if (msg_byte == 8'd0) begin
						phase_d = PH_SRC_PORT_LO;
					end else begin
						field_d = msg_byte;
						phase_d = PH_SRC_ADDR;
					end
				end
				PH_SRC_ADDR: begin
					field_d = field_dec;
					if (field_dec == 8'd0) phase_d = PH_SRC_PORT_LO;
				end
				PH_SRC_PORT_LO: begin
					sport_d = {8'd0, msg_byte};
					phase_d = PH_SRC_PORT_HI;
				end
				PH_SRC_PORT_HI: begin
					sport_d = {msg_byte, sport_q[7:0]};
					phase_d = PH_DST_LEN;
				end
				PH_DST_LEN: begin
					match_d = (msg_byte == {3'd0, cfg.id_len});
					idx_d   = '0;
					if (msg_byte > ADDR_MAX) begin
						drop_d = 1'b1;
					end else if (msg_byte == 8'd0) begin
						phase_d = PH_DST_PORT_LO;
					end else begin
						field_d = msg_byte;
						phase_d = PH_DST_ADDR;
					end
				end
				PH_DST_ADDR: begin
					// bytes past the identity width never match
					if (idx_q >= ID_BYTES || msg_byte != id_sel) match_d = 1'b0;
					if (idx_q != IDX_SAT) idx_d = idx_q + 5'd1;
					field_d = field_dec;
					if (field_dec == 8'd0) phase_d = PH_DST_PORT_LO;
				end
				PH_DST_PORT_LO: begin
					dport_d = {8'd0, msg_byte};
					phase_d = PH_DST_PORT_HI;
				end
				PH_DST_PORT_HI: begin
					dport_d = {msg_byte, dport_q[7:0]};
					field_d = SKIP_BYTES;
					phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					field_d = field_dec;
					if (field_dec == 8'd0) begin
						match_d = port_ok;
						if (!port_ok) begin
							drop_d = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
							// header ends the message: one empty result
							if (msg_last) begin
								res_d.valid        = 1'b1;
								res_d.payload_byte = 8'd0;
								res_d.first_byte   = 1'b1;
								res_d.last_byte    = 1'b1;
								res_d.no_payload   = 1'b1;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					res_d.valid      = 1'b1;
					res_d.first_byte = !started_q;
					res_d.last_byte  = msg_last;
					started_d        = 1'b1;
				end
				default: drop_d = 1'b1;
			endcase
		end

		if (msg_last) begin
			phase_d   = PH_MAGIC_A;
			field_d   = '0;
			idx_d     = '0;
			match_d   = 1'b1;
			drop_d    = 1'b0;
			started_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC_A;
			field_q   <= '0;
			idx_q     <= '0;
			match_q   <= 1'b1;
			sport_q   <= '0;
			dport_q   <= '0;
			drop_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			field_q   <= field_d;
			idx_q     <= idx_d;
			match_q   <= match_d;
			sport_q   <= sport_d;
			dport_q   <= dport_d;
			drop_q    <= drop_d;
			started_q <= started_d;
		end
	end

	always_comb begin
		res       = res_d;
		res.valid = res_d.valid && step_en;
	end

`ifndef SYNTHESIS
	a_res_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!drop_q && (phase_q == PH_SKIP || phase_q == PH_PAYLOAD)))
		else $error("result outside skip/payload phase");

	a_msg_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && msg_last) |=> (phase_q == PH_MAGIC_A && !drop_q && !started_q && match_q))
		else $error("parse state not cleared after last byte");

	a_started_payload: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (phase_q == PH_PAYLOAD && !drop_q))
		else $error("payload started outside payload phase");
`endif

endmodule

[rtl/tunnel_packet_header_filter_unit.sv]
// ----------------------------------------------------------------------------
// tunnel_packet_header_filter_unit
// Filters tunnel packets addressed to this node and forwards their payload.
// ----------------------------------------------------------------------------
// A request is registered in the input stage, then the parser writes its result
// into the output register, which presents it.
// Throughput: one byte per cycle while in_stall is low; the parse state is a
// single one-hot phase register updated per byte, with a one-entry input stage.
// Reset: arst_n clears the parse state, the pipeline valids and the config
// registers (identity 0, identity length 1, port 0).
module tunnel_packet_header_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tphf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tphf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        msg_byte,
	input  logic                              msg_last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        payload_byte,
	output logic [15:0]                       src_port,
	output logic                              first_byte,
	output logic                              last_byte,
	output logic                              no_payload
);
	import tphf_pkg::*;

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       step_en;
	logic       out_valid_q;
	logic [7:0] payload_q;
	logic [15:0] src_port_q;
	logic       first_q;
	logic       last_q;
	logic       empty_q;

	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	tphf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= msg_byte;
			last_s1 <= msg_last;
		end
	end

	tphf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.msg_byte (byte_s1),
		.msg_last (last_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			payload_q  <= res.payload_byte;
			src_port_q <= res.src_port;
			first_q    <= res.first_byte;
			last_q     <= res.last_byte;
			empty_q    <= res.no_payload;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign src_port     = src_port_q;
	assign first_byte   = first_q;
	assign last_byte    = last_q;
	assign no_payload   = empty_q;

`ifndef SYNTHESIS
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (first_q && last_q && payload_q == 8'd0))
		else $error("empty-payload result malformed");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid) |=> out_valid_q)
		else $error("parser result lost");
`endif

endmodule
